FILE: src/tpds_pkg.sv
// Shared types, constants and helpers for the two-phase deadline scheduler.
// No dependencies; every other file in src imports this package.
package tpds_pkg;

   localparam int TIME_W = 32;

   localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

   // Operation carried with each input transaction
   localparam logic OP_POLL    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_PERIOD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_PERIOD = 2'd1;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_LOW  = 2'd1,
      PHASE_HIGH = 2'd2
   } phase_type;

   typedef struct packed {
      logic [TIME_W-1:0] low_deadline;
      logic [TIME_W-1:0] high_deadline;
      logic [TIME_W-1:0] overrun_count;
   } sched_state_type;

   // True when now is at or past the deadline, by signed wrapping difference
   function automatic logic reached(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] deadline);
      logic [TIME_W-1:0] diff;
      diff = now - deadline;
      return ~diff[TIME_W-1];
   endfunction

endpackage

FILE: src/tpds_core.sv
// Deadline and overrun state of the scheduler with its per-transaction update.
// Depends on tpds_pkg.
module tpds_core
   import tpds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 op,
   input  logic [TIME_W-1:0]    now_time,
   input  logic [TIME_W-1:0]    low_period,
   input  logic [TIME_W-1:0]    high_period,
   output sched_state_type      state,
   output phase_type            phase
);

   sched_state_type state_ff;
   sched_state_type state_in;

   logic              high_due;
   logic              low_due;
   logic [TIME_W-1:0] sel_deadline;
   logic [TIME_W-1:0] sel_period;
   logic [TIME_W-1:0] adv_deadline;
   logic [TIME_W-1:0] new_deadline;
   logic              overrun;
   logic [TIME_W-1:0] bumped_count;

   assign high_due = (high_period != '0) && reached(now_time, state_ff.high_deadline);
   assign low_due  = (low_period  != '0) && reached(now_time, state_ff.low_deadline);

   always_comb begin
      if (high_due) begin
         sel_deadline = state_ff.high_deadline;
         sel_period   = high_period;
      end else begin
         sel_deadline = state_ff.low_deadline;
         sel_period   = low_period;
      end
      adv_deadline = sel_deadline + sel_period;
      overrun      = reached(now_time, adv_deadline);
      // re-anchor at now plus period when the advanced deadline is already past
      new_deadline = overrun ? (now_time + sel_period) : adv_deadline;
      bumped_count = (state_ff.overrun_count == ALL_ONES) ?
                     state_ff.overrun_count : (state_ff.overrun_count + 1'b1);
   end

   always_comb begin
      state_in = state_ff;
      phase    = PHASE_IDLE;
      if (op == OP_RESTART) begin
         state_in.low_deadline  = now_time + low_period;
         state_in.high_deadline = now_time + high_period;
         state_in.overrun_count = '0;
      end else if (high_due) begin
         state_in.high_deadline = new_deadline;
         phase                  = PHASE_HIGH;
         if (overrun) begin
            state_in.overrun_count = bumped_count;
         end
      end else if (low_due) begin
         state_in.low_deadline = new_deadline;
         phase                 = PHASE_LOW;
         if (overrun) begin
            state_in.overrun_count = bumped_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

FILE: src/tpds_delay.sv
// Time to the nearest enabled deadline, all ones when both phases are off.
// Depends on tpds_pkg.
module tpds_delay
   import tpds_pkg::*;
(
   input  logic [TIME_W-1:0] now_time,
   input  logic [TIME_W-1:0] low_period,
   input  logic [TIME_W-1:0] high_period,
   input  sched_state_type   state,
   output logic [TIME_W-1:0] delay_to_next
);

   logic [TIME_W-1:0] low_delay;
   logic [TIME_W-1:0] high_delay;

   always_comb begin
      low_delay  = reached(now_time, state.low_deadline) ?
                   '0 : (state.low_deadline - now_time);
      high_delay = reached(now_time, state.high_deadline) ?
                   '0 : (state.high_deadline - now_time);
      delay_to_next = ALL_ONES;
      if (low_period != '0) begin
         delay_to_next = low_delay;
      end
      if ((high_period != '0) && (high_delay < delay_to_next)) begin
         delay_to_next = high_delay;
      end
   end

endmodule

FILE: src/two_phase_deadline_scheduler.sv
// Top level of the two-phase periodic deadline scheduler.
// Depends on tpds_pkg, tpds_core and tpds_delay.
//
// Usage:
//   req channel: one transaction per poll or restart. req_tuser is the op
//   (0 poll, 1 restart), req_tdata the current time in ms.
//   rsp channel: one transaction per request with the fired phase, the delay
//   to the nearest enabled deadline and the overrun count.
//   csr channel: index 0 writes the low-priority period, index 1 the
//   high-priority period; other indexes are ignored. Always ready; write only
//   while no request is in flight. Zero disables a phase.
// Pipeline: input register, state update stage, result register; a request
//   accepted into the input register reaches rsp through the other two.
// Throughput: one request per cycle while rsp_tready does not stall. The deadline
//   update of one request is combinational between the input register and the
//   state registers; the delay search runs one stage later on the updated state.
// Reset: periods, deadlines and overrun count clear; both phases start off.
// Stall: when rsp_tready is low the result register holds, the stages behind
//   it fill, and req_tready drops once all three registers are occupied.
module two_phase_deadline_scheduler
   import tpds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TIME_W-1:0]    req_tdata,   // [31:0] now_time
   input  logic                 req_tuser,   // [0] op
   // response stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,   // [1:0] phase, [33:2] delay_to_next,
                                             // [65:34] overrun_total, [71:66] zero
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_data
);

   logic [TIME_W-1:0] low_period_ff;
   logic [TIME_W-1:0] high_period_ff;

   logic              in_valid_ff;
   logic              in_op_ff;
   logic [TIME_W-1:0] in_now_ff;

   logic              mid_valid_ff;
   logic [TIME_W-1:0] mid_now_ff;
   phase_type         mid_phase_ff;

   logic              out_valid_ff;
   phase_type         out_phase_ff;
   logic [TIME_W-1:0] out_delay_ff;
   logic [TIME_W-1:0] out_overrun_ff;

   logic              out_ready;
   logic              mid_ready;
   logic              in_ready;
   logic              mid_move;
   logic              in_move;

   sched_state_type   state;
   phase_type         phase;
   logic [TIME_W-1:0] delay_to_next;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign mid_ready  = !mid_valid_ff || out_ready;
   assign in_ready   = !in_valid_ff || mid_ready;
   assign mid_move   = mid_valid_ff && out_ready;
   assign in_move    = in_valid_ff && mid_ready;
   assign req_tready = in_ready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_period_ff  <= '0;
         high_period_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOW_PERIOD:  low_period_ff  <= csr_data;
            CSR_HIGH_PERIOD: high_period_ff <= csr_data;
            default: ;
         endcase
      end
   end

   tpds_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (in_move),
      .op          (in_op_ff),
      .now_time    (in_now_ff),
      .low_period  (low_period_ff),
      .high_period (high_period_ff),
      .state       (state),
      .phase       (phase)
   );

   // state already holds the update of the transaction in the mid stage
   tpds_delay u_delay (
      .now_time      (mid_now_ff),
      .low_period    (low_period_ff),
      .high_period   (high_period_ff),
      .state         (state),
      .delay_to_next (delay_to_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_tvalid;
         end
         if (mid_ready) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= mid_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_tvalid) begin
         in_op_ff  <= req_tuser;
         in_now_ff <= req_tdata;
      end
      if (in_move) begin
         mid_now_ff   <= in_now_ff;
         mid_phase_ff <= phase;
      end
      if (mid_move) begin
         out_phase_ff   <= mid_phase_ff;
         out_delay_ff   <= delay_to_next;
         out_overrun_ff <= state.overrun_count;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_overrun_ff, out_delay_ff, out_phase_ff};

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the two-phase deadline scheduler.
// Depends on tpds_pkg and two_phase_deadline_scheduler in src; predicts each response
// from its own model of the periods, deadlines and overrun count.
`timescale 1ns / 1ps

module tb_top
   import tpds_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;
   localparam int MAX_GAP = 4;

   typedef struct {
      phase_type         phase;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] overruns;
   } sched_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [TIME_W-1:0]    req_tdata = '0;
   logic                 req_tuser = OP_POLL;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [71:0]          rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LOW_PERIOD;
   logic [TIME_W-1:0]    csr_data = '0;

   // scheduler model state
   logic [TIME_W-1:0] exp_low_period = '0;
   logic [TIME_W-1:0] exp_high_period = '0;
   logic [TIME_W-1:0] exp_low_due = '0;
   logic [TIME_W-1:0] exp_high_due = '0;
   logic [TIME_W-1:0] exp_overruns = '0;

   sched_result_type sched_result_q[$];
   int               err_count = 0;
   bit               gaps_on = 1'b0;
   int               rsp_wait = 0;
   int               rsp_block = 0;

   two_phase_deadline_scheduler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic at_or_past(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] due);
      logic [TIME_W-1:0] diff;
      diff = now - due;
      return !diff[TIME_W-1];
   endfunction

   // Step a fired deadline by one period; re-anchor on overrun and count it.
   task automatic advance_deadline(inout logic [TIME_W-1:0] due,
                                   input logic [TIME_W-1:0] period,
                                   input logic [TIME_W-1:0] now);
      due = due + period;
      if (at_or_past(now, due)) begin
         due = now + period;
         if (exp_overruns != ALL_ONES) exp_overruns = exp_overruns + 1;
      end
   endtask

   task automatic predict_schedule(input logic op, input logic [TIME_W-1:0] now);
      phase_type         ph;
      logic [TIME_W-1:0] nearest;
      logic [TIME_W-1:0] d;
      ph = PHASE_IDLE;
      nearest = ALL_ONES;
      if (op == OP_RESTART) begin
         exp_low_due = now + exp_low_period;
         exp_high_due = now + exp_high_period;
         exp_overruns = '0;
      end else if (exp_high_period != 0 && at_or_past(now, exp_high_due)) begin
         advance_deadline(exp_high_due, exp_high_period, now);
         ph = PHASE_HIGH;
      end else if (exp_low_period != 0 && at_or_past(now, exp_low_due)) begin
         advance_deadline(exp_low_due, exp_low_period, now);
         ph = PHASE_LOW;
      end
      if (exp_low_period != 0)
         nearest = at_or_past(now, exp_low_due) ? '0 : exp_low_due - now;
      if (exp_high_period != 0) begin
         d = at_or_past(now, exp_high_due) ? '0 : exp_high_due - now;
         if (d < nearest) nearest = d;
      end
      sched_result_q.push_back('{ph, nearest, exp_overruns});
   endtask

   task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                  input logic [TIME_W-1:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      err_count++;
   endtask

   // Hold valid across back-to-back transactions; drop it only for a gap.
   task automatic send_item(input logic op, input logic [TIME_W-1:0] now);
      int gap;
      gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= now;
      do @(posedge clock); while (!req_tready);
      predict_schedule(op, now);
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (sched_result_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_LOW_PERIOD) exp_low_period = val;
      else if (idx == CSR_HIGH_PERIOD) exp_high_period = val;
   endtask

   // Response side: random stall after each transaction, plus long hold-offs on request.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) rsp_wait = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         if (rsp_block > 0) begin
            rsp_block--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      sched_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sched_result_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[33:2], '0);
         end else begin
            want = sched_result_q.pop_front();
            if (rsp_tdata[1:0] !== want.phase)
               report_mismatch("phase", rsp_tdata[1:0], want.phase);
            if (rsp_tdata[33:2] !== want.delay)
               report_mismatch("delay_to_next", rsp_tdata[33:2], want.delay);
            if (rsp_tdata[65:34] !== want.overruns)
               report_mismatch("overrun_total", rsp_tdata[65:34], want.overruns);
            if (rsp_tdata[71:66] !== 6'd0)
               report_mismatch("padding", rsp_tdata[71:66], '0);
         end
      end
   end

   // Both periods are zero out of reset: nothing fires and no deadline counts.
   task automatic test_disabled_phases();
      gaps_on = 1'b0;
      send_item(OP_POLL, 32'h0000_0000);
      send_item(OP_POLL, 32'hFFFF_FFFF);
      send_item(OP_RESTART, 32'h1234_5678);
      drain_pipeline();
   endtask

   // Priority, wrap of the clock, and re-anchoring after an overrun.
   task automatic test_priority_and_overrun();
      csr_write(CSR_LOW_PERIOD, 32'd10);
      csr_write(CSR_HIGH_PERIOD, 32'd4);
      send_item(OP_RESTART, 32'hFFFF_FFF8);
      send_item(OP_POLL, 32'hFFFF_FFFB);
      send_item(OP_POLL, 32'hFFFF_FFFC);
      send_item(OP_POLL, 32'h0000_0002);
      send_item(OP_POLL, 32'h0000_0002);
      send_item(OP_POLL, 32'h0000_0064);
      send_item(OP_POLL, 32'h0000_0064);
      send_item(OP_POLL, 32'h8000_0000);
      send_item(OP_RESTART, 32'h0000_0000);
      drain_pipeline();
   endtask

   // Period changes without restart keep the deadlines; stray indexes do nothing.
   task automatic test_period_rewrite();
      csr_write(CSR_HIGH_PERIOD, 32'd0);
      send_item(OP_POLL, 32'h0000_0003);
      drain_pipeline();
      csr_write(CSR_HIGH_PERIOD, ALL_ONES);
      csr_write(CSR_UNUSED_A, ALL_ONES);
      csr_write(CSR_UNUSED_B, ALL_ONES);
      send_item(OP_POLL, 32'h0000_0004);
      send_item(OP_POLL, 32'h7FFF_FFFF);
      drain_pipeline();
      csr_write(CSR_LOW_PERIOD, 32'd1);
      send_item(OP_RESTART, 32'h0000_0010);
      send_item(OP_POLL, 32'h0000_0011);
      send_item(OP_POLL, 32'h0000_0011);
      drain_pipeline();
   endtask

   // Fill the pipeline against a stalled receiver, pause until it empties, then poll with gaps.
   task automatic test_backpressure();
      int k;
      logic [TIME_W-1:0] t;
      csr_write(CSR_LOW_PERIOD, 32'd7);
      csr_write(CSR_HIGH_PERIOD, 32'd3);
      gaps_on = 1'b0;
      t = $urandom;
      send_item(OP_RESTART, t);
      rsp_block = 60;
      for (k = 0; k < 40; k++) begin
         t = t + $urandom_range(0, 4);
         send_item(OP_POLL, t);
      end
      drain_pipeline();
      gaps_on = 1'b1;
      for (k = 0; k < 20; k++) begin
         t = t + $urandom_range(0, 6);
         send_item(OP_POLL, t);
      end
      drain_pipeline();
   endtask

   function automatic logic [TIME_W-1:0] pick_period(input int sel);
      case (sel)
         0: return '0;
         1: return 32'd1;
         2: return ALL_ONES;
         3: return $urandom_range(2, 20);
         4: return $urandom_range(21, 500);
         default: return $urandom;
      endcase
   endfunction

   // Time step scale: the shortest enabled period, kept within a sane window.
   function automatic int unsigned step_span();
      logic [TIME_W-1:0] m;
      m = ALL_ONES;
      if (exp_low_period != 0) m = exp_low_period;
      if (exp_high_period != 0 && exp_high_period < m) m = exp_high_period;
      if (m == ALL_ONES && exp_low_period == 0 && exp_high_period == 0) return 100;
      return (m > 1000) ? 1000 : m;
   endfunction

   // Mostly forward-moving polls, some late polls for overruns, plus restarts and noise.
   task automatic test_random_schedule();
      int                p;
      int                k;
      int unsigned       roll;
      int unsigned       span;
      logic [TIME_W-1:0] t;
      for (p = 0; p < 12; p++) begin
         drain_pipeline();
         gaps_on = ($urandom_range(0, 3) != 0);
         case (p)
            0: begin
               csr_write(CSR_LOW_PERIOD, ALL_ONES);
               csr_write(CSR_HIGH_PERIOD, ALL_ONES);
            end
            1: begin
               csr_write(CSR_LOW_PERIOD, 32'd1);
               csr_write(CSR_HIGH_PERIOD, 32'd1);
            end
            2: begin
               csr_write(CSR_LOW_PERIOD, $urandom_range(2, 20));
               csr_write(CSR_HIGH_PERIOD, '0);
            end
            default: begin
               csr_write(CSR_LOW_PERIOD, pick_period($urandom_range(0, 5)));
               csr_write(CSR_HIGH_PERIOD, pick_period($urandom_range(0, 5)));
            end
         endcase
         if ($urandom_range(0, 3) == 0)
            csr_write($urandom_range(0, 1) ? CSR_UNUSED_A : CSR_UNUSED_B, $urandom);
         span = step_span();
         t = $urandom;
         send_item(OP_RESTART, t);
         for (k = 0; k < 100; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
               t = t + $urandom_range(0, span);
               send_item(OP_POLL, t);
            end else if (roll < 85) begin
               t = t + $urandom_range(span, 4 * span);
               send_item(OP_POLL, t);
            end else if (roll < 90) begin
               t = $urandom;
               send_item(OP_POLL, t);
            end else if (roll < 94) begin
               send_item(OP_RESTART, t);
            end else begin
               send_item($urandom_range(0, 1) ? OP_RESTART : OP_POLL, $urandom);
            end
         end
      end
      drain_pipeline();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_disabled_phases();
      test_priority_and_overrun();
      test_period_rewrite();
      test_backpressure();
      test_random_schedule();
      req_tvalid <= 1'b0;
      while (sched_result_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0 && sched_result_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
